>>> hw/rtl/dsl_pkg.sv
// Shared types and constants of the serial tuning-word loader.
`default_nettype none

package dsl_pkg;

    // Command codes carried by a request
    localparam logic [2:0] CmdTick     = 3'd0;
    localparam logic [2:0] CmdSetPhase = 3'd1;
    localparam logic [2:0] CmdPhaseUp  = 3'd2;
    localparam logic [2:0] CmdPhaseDn  = 3'd3;
    localparam logic [2:0] CmdUpdate   = 3'd4;
    localparam logic [2:0] CmdResetSeq = 3'd5;

    // Status codes
    localparam logic [1:0] StatOk    = 2'd0;
    localparam logic [1:0] StatBusy  = 2'd1;
    localparam logic [1:0] StatLimit = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] RegTuningWord = 3'd0;
    localparam logic [2:0] RegOutputOn   = 3'd1;
    localparam logic [2:0] RegAutoUpdate = 3'd2;
    localparam logic [2:0] RegSetupTicks = 3'd3;
    localparam logic [2:0] RegPulseTicks = 3'd4;
    localparam logic [2:0] RegHoldTicks  = 3'd5;
    localparam logic [2:0] RegMinPhase   = 3'd6;
    localparam logic [2:0] RegMaxPhase   = 3'd7;

    localparam logic [4:0] PhaseMax   = 5'd31;
    localparam int         FrameBits  = 40;
    localparam logic [7:0] TicksReset = 8'd1;

    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] phase_step;
    } t_in_item;

    typedef struct packed {
        logic       serial_clock;
        logic       serial_data;
        logic       update_strobe;
        logic       chip_reset;
        logic       busy_res;
        logic [1:0] status;
        logic [4:0] phase_now;
    } t_out_item;

    typedef struct packed {
        logic [31:0] tuning_word;
        logic        output_on;
        logic        auto_update;
        logic [7:0]  setup_ticks;
        logic [7:0]  pulse_ticks;
        logic [7:0]  hold_ticks;
        logic [4:0]  min_phase_step;
        logic [4:0]  max_phase_step;
    } t_cfg;

endpackage

`default_nettype wire

>>> hw/rtl/dds_serial_word_loader.sv
// Top level: configuration registers, sequencer and result queue.
`default_nettype none

// Serial tuning-word loader. Each request is one timing tick, optionally
// carrying a command (set phase, phase up/down, update, reset sequence).
// A frame shifts 40 bits LSB first (32-bit tuning word, then the control
// byte: phase << 3 plus the power-down bit when the output is off) with
// setup/pulse/hold tick counts per bit, then pulses the update strobe.
// The block takes one request every clock while the queue has room: the
// request is decoded against the sequencer registers in the same cycle and
// its result (pin levels, busy, status, phase) is written into a two-entry
// queue, so the result appears in the cycle after acceptance and a new
// request is taken while one result still waits. Input ready drops only
// when both queue entries are full. Pin timing is counted in requests, not
// clocks. Configuration is a plain write port, taken every cycle the write
// enable is high; tuning word and output enable are captured when a frame starts.

module dds_serial_word_loader #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire dsl_pkg::t_in_item  i_data,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output dsl_pkg::t_out_item      o_data,
    // configuration write port
    input  wire logic               i_cfg_wr_en,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [31:0]        i_cfg_wdata
);

    dsl_pkg::t_cfg      r_cfg;
    dsl_pkg::t_out_item seq_result;
    logic               step;

    // config registers, reset to the documented defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tuning_word    <= '0;
            r_cfg.output_on      <= 1'b0;
            r_cfg.auto_update    <= 1'b0;
            r_cfg.setup_ticks    <= dsl_pkg::TicksReset;
            r_cfg.pulse_ticks    <= dsl_pkg::TicksReset;
            r_cfg.hold_ticks     <= dsl_pkg::TicksReset;
            r_cfg.min_phase_step <= '0;
            r_cfg.max_phase_step <= dsl_pkg::PhaseMax;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                dsl_pkg::RegTuningWord: r_cfg.tuning_word    <= i_cfg_wdata;
                dsl_pkg::RegOutputOn:   r_cfg.output_on      <= i_cfg_wdata[0];
                dsl_pkg::RegAutoUpdate: r_cfg.auto_update    <= i_cfg_wdata[0];
                dsl_pkg::RegSetupTicks: r_cfg.setup_ticks    <= i_cfg_wdata[7:0];
                dsl_pkg::RegPulseTicks: r_cfg.pulse_ticks    <= i_cfg_wdata[7:0];
                dsl_pkg::RegHoldTicks:  r_cfg.hold_ticks     <= i_cfg_wdata[7:0];
                dsl_pkg::RegMinPhase:   r_cfg.min_phase_step <= i_cfg_wdata[4:0];
                dsl_pkg::RegMaxPhase:   r_cfg.max_phase_step <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // a request advances the sequencer only when its result has a slot
    assign step = i_valid && o_ready;

    dsl_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (i_data),
        .i_cfg    (r_cfg),
        .o_result (seq_result)
    );

    dsl_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step),
        .i_data     (seq_result),
        .o_not_full (o_ready),
        .o_valid    (o_valid),
        .i_pop      (i_ready),
        .o_data     (o_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/dsl_seq.sv
// Command decode, frame/reset sequencer and pin level logic.
`default_nettype none

module dsl_seq #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire dsl_pkg::t_in_item i_item,
    input  wire dsl_pkg::t_cfg     i_cfg,
    output dsl_pkg::t_out_item     o_result
);

    localparam logic [3:0] StIdle     = 4'd0;
    localparam logic [3:0] StBitSetup = 4'd1;
    localparam logic [3:0] StBitHigh  = 4'd2;
    localparam logic [3:0] StBitHold  = 4'd3;
    localparam logic [3:0] StUpdSetup = 4'd4;
    localparam logic [3:0] StUpdHigh  = 4'd5;
    localparam logic [3:0] StUpdHold  = 4'd6;
    localparam logic [3:0] StRstHigh  = 4'd7;
    localparam logic [3:0] StRstHold  = 4'd8;
    localparam logic [3:0] StRclkHigh = 4'd9;
    localparam logic [3:0] StRclkHold = 4'd10;
    localparam logic [3:0] StRfqHigh  = 4'd11;
    localparam logic [3:0] StRfqHold  = 4'd12;

    localparam int CmpW = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
    localparam logic [CmpW-1:0] CntMaxW = CmpW'({COUNT_WIDTH{1'b1}});
    localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

    // zero acts as one, too large saturates to the counter range
    function automatic logic [COUNT_WIDTH-1:0] clamp_ticks(input logic [7:0] v);
        logic [CmpW-1:0] ve;
        ve = CmpW'(v);
        if (v == 8'd0) return CntOne;
        else if (ve > CntMaxW) return {COUNT_WIDTH{1'b1}};
        else return COUNT_WIDTH'(ve);
    endfunction

    logic [3:0]             r_state, n_state;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [39:0]            r_shift, n_shift;
    logic [5:0]             r_bits, n_bits;
    logic [4:0]             r_phase, n_phase;

    logic [COUNT_WIDTH-1:0] setup_c, pulse_c, hold_c;
    logic [3:0]             adv_state;
    logic [4:0]             cand_phase;
    logic                   cand_ok;
    logic [1:0]             status;
    logic                   start_frame;
    logic [7:0]             ctrl_byte;

    assign setup_c = clamp_ticks(i_cfg.setup_ticks);
    assign pulse_c = clamp_ticks(i_cfg.pulse_ticks);
    assign hold_c  = clamp_ticks(i_cfg.hold_ticks);

    // phase candidate for the three phase commands
    always_comb begin
        unique case (i_item.cmd)
            dsl_pkg::CmdPhaseUp:
                cand_phase = (r_phase != dsl_pkg::PhaseMax) ? r_phase + 5'd1 : r_phase;
            dsl_pkg::CmdPhaseDn:
                cand_phase = (r_phase != 5'd0) ? r_phase - 5'd1 : r_phase;
            default:
                cand_phase = i_item.phase_step;
        endcase
        cand_ok = (cand_phase >= i_cfg.min_phase_step) &&
                  (cand_phase <= i_cfg.max_phase_step);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_bits      = r_bits;
        n_phase     = r_phase;
        status      = dsl_pkg::StatOk;
        start_frame = 1'b0;
        adv_state   = StIdle;
        ctrl_byte   = 8'd0;

        if (r_state != StIdle) begin
            if (i_item.cmd != dsl_pkg::CmdTick && i_item.cmd <= dsl_pkg::CmdResetSeq) begin
                status = dsl_pkg::StatBusy;
            end
            if (r_cnt > CntOne) begin
                n_cnt = r_cnt - CntOne;
            end else begin
                unique case (r_state)
                    StBitSetup: adv_state = StBitHigh;
                    StBitHigh:  adv_state = StBitHold;
                    StBitHold: begin
                        n_shift = {1'b0, r_shift[39:1]};
                        n_bits  = (r_bits != 6'd0) ? r_bits - 6'd1 : r_bits;
                        adv_state = (n_bits != 6'd0) ? StBitSetup : StUpdSetup;
                    end
                    StUpdSetup: adv_state = StUpdHigh;
                    StUpdHigh:  adv_state = StUpdHold;
                    StRstHigh:  adv_state = StRstHold;
                    StRstHold:  adv_state = StRclkHigh;
                    StRclkHigh: adv_state = StRclkHold;
                    StRclkHold: adv_state = StRfqHigh;
                    StRfqHigh:  adv_state = StRfqHold;
                    default:    adv_state = StIdle;
                endcase
                n_state = adv_state;
                unique case (adv_state)
                    StIdle:                 n_cnt = '0;
                    StBitSetup, StUpdSetup: n_cnt = setup_c;
                    StBitHigh, StUpdHigh, StRstHigh, StRclkHigh, StRfqHigh:
                                            n_cnt = pulse_c;
                    default:                n_cnt = hold_c;
                endcase
            end
        end else begin
            unique case (i_item.cmd)
                dsl_pkg::CmdSetPhase, dsl_pkg::CmdPhaseUp, dsl_pkg::CmdPhaseDn: begin
                    if (cand_ok) begin
                        n_phase     = cand_phase;
                        start_frame = i_cfg.auto_update;
                    end else begin
                        status = dsl_pkg::StatLimit;
                    end
                end
                dsl_pkg::CmdUpdate:   start_frame = 1'b1;
                dsl_pkg::CmdResetSeq: begin
                    n_state = StRstHigh;
                    n_cnt   = pulse_c;
                end
                default: ;
            endcase
            if (start_frame) begin
                // control byte carries the phase just stored
                ctrl_byte = {n_phase, ~i_cfg.output_on, 2'b00};
                n_shift = {ctrl_byte, i_cfg.tuning_word};
                n_bits  = 6'(dsl_pkg::FrameBits);
                n_state = StBitSetup;
                n_cnt   = setup_c;
            end
        end
    end

    // pin levels follow the state after this request
    always_comb begin
        o_result.serial_clock  = (n_state == StBitHigh) || (n_state == StRclkHigh);
        o_result.serial_data   = ((n_state == StBitSetup) || (n_state == StBitHigh))
                                 && n_shift[0];
        o_result.update_strobe = (n_state == StUpdHigh) || (n_state == StRfqHigh);
        o_result.chip_reset    = (n_state == StRstHigh);
        o_result.busy_res      = (n_state != StIdle);
        o_result.status        = status;
        o_result.phase_now     = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_cnt   <= '0;
            r_shift <= '0;
            r_bits  <= '0;
            r_phase <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_phase <= n_phase;
        end
    end

    // idle always has an empty tick counter, a running phase never does
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StIdle) |-> (r_cnt == '0))
        else $error("tick counter nonzero while idle");

    a_run_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |-> (r_cnt != '0))
        else $error("running phase with empty tick counter");

    // at most one of clock, strobe and reset is driven high
    a_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_result.serial_clock, o_result.update_strobe, o_result.chip_reset}))
        else $error("more than one pulse pin high");

    // a busy request leaves the phase untouched
    a_busy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_state != StIdle) |=> (r_phase == $past(r_phase)))
        else $error("phase changed while busy");

endmodule

`default_nettype wire

>>> hw/rtl/dsl_outq.sv
// Two-entry result queue between the sequencer and the output channel.
`default_nettype none

module dsl_outq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire dsl_pkg::t_out_item i_data,
    output logic                    o_not_full,
    output logic                    o_valid,
    input  wire logic               i_pop,
    output dsl_pkg::t_out_item      o_data
);

    dsl_pkg::t_out_item r_mem [2];
    logic               r_wr_ptr, r_rd_ptr;
    logic [1:0]         r_count;
    logic               pop_en;

    assign o_valid    = (r_count != 2'd0);
    assign o_not_full = (r_count != 2'd2);
    assign o_data     = r_mem[r_rd_ptr];
    assign pop_en     = o_valid && i_pop;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop_en) r_rd_ptr <= ~r_rd_ptr;
            if (i_push && !pop_en)      r_count <= r_count + 2'd1;
            else if (!i_push && pop_en) r_count <= r_count - 2'd1;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue overfilled");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill level");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop_en) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue count did not follow a push");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the serial tuning-word loader.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes the block has no action for; they still tick the sequencer.
    localparam logic [2:0] CmdSpare6   = 3'd6;
    localparam logic [2:0] CmdSpare7   = 3'd7;
    // Power-down bit of the control byte, set while the output is off.
    localparam logic [7:0] PwrDownBit  = 8'h04;
    // Cycles without any handshake before the run is declared hung.
    localparam int         QuietLimit  = 4000;
    // Receiver hold-off used to fill the block and back-pressure requests.
    localparam int         HoldCycles  = 400;
    localparam int         DrainBatch  = 32;

    // Pin sequencer states of the predictor (request-counted timing).
    typedef enum logic [3:0] {
        SqIdle, SqBitSetup, SqBitHigh, SqBitHold, SqUpdSetup, SqUpdHigh, SqUpdHold,
        SqRstHigh, SqRstHold, SqClkHigh, SqClkHold, SqFqHigh, SqFqHold
    } t_seq;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    dsl_pkg::t_in_item  i_data;
    logic               o_valid;
    logic               i_ready;
    dsl_pkg::t_out_item o_data;
    logic               i_cfg_wr_en;
    logic [2:0]         i_cfg_addr;
    logic [31:0]        i_cfg_wdata;

    dds_serial_word_loader DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and the sequencer.
    // ------------------------------------------------------------------
    dsl_pkg::t_cfg      cfg_m;
    logic [4:0]         m_phase;
    logic [39:0]        m_frame;
    logic [5:0]         m_bits;
    t_seq               m_seq;
    logic [7:0]         m_ticks;

    dsl_pkg::t_in_item  req_q[$];        // requests waiting to be offered
    dsl_pkg::t_out_item pin_expect_q[$]; // predicted results, oldest first

    int fail_cnt;
    int tx_gap_pct;               // chance per cycle that the sender stays idle
    int rx_stall_pct;             // chance per cycle that the receiver stalls
    int hold_left;                // long receiver hold-off, counted down below
    int quiet_cycles;

    // A tick register of zero behaves as one.
    function automatic logic [7:0] tick_len(logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic void enter_seq(t_seq s);
        m_seq = s;
        case (s)
            SqBitSetup, SqUpdSetup: m_ticks = tick_len(cfg_m.setup_ticks);
            SqBitHigh, SqUpdHigh, SqRstHigh, SqClkHigh, SqFqHigh:
                m_ticks = tick_len(cfg_m.pulse_ticks);
            SqIdle: m_ticks = 8'd0;
            default: m_ticks = tick_len(cfg_m.hold_ticks);
        endcase
    endfunction

    // Tuning word and output enable are captured here, at frame start.
    function automatic void load_frame();
        logic [7:0] ctrl;
        ctrl = {m_phase, 3'b000};
        if (!cfg_m.output_on) ctrl = ctrl | PwrDownBit;
        m_frame = {ctrl, cfg_m.tuning_word};
        m_bits = 6'(dsl_pkg::FrameBits);
        enter_seq(SqBitSetup);
    endfunction

    function automatic logic [1:0] accept_phase(logic [4:0] np);
        if (np < cfg_m.min_phase_step || np > cfg_m.max_phase_step)
            return dsl_pkg::StatLimit;
        m_phase = np;
        if (cfg_m.auto_update) load_frame();
        return dsl_pkg::StatOk;
    endfunction

    // Advance the predictor by one request and return the pin/status result.
    function automatic dsl_pkg::t_out_item next_pin_state(dsl_pkg::t_in_item rq);
        dsl_pkg::t_out_item r;
        logic [1:0]         st;
        st = dsl_pkg::StatOk;
        if (m_seq != SqIdle) begin
            // Busy: any real command is refused, the sequence just ticks on.
            if (rq.cmd != dsl_pkg::CmdTick && rq.cmd <= dsl_pkg::CmdResetSeq)
                st = dsl_pkg::StatBusy;
            if (m_ticks > 8'd1) begin
                m_ticks = m_ticks - 8'd1;
            end else begin
                case (m_seq)
                    SqBitSetup: enter_seq(SqBitHigh);
                    SqBitHigh:  enter_seq(SqBitHold);
                    SqBitHold: begin
                        m_frame = m_frame >> 1;
                        if (m_bits != 6'd0) m_bits = m_bits - 6'd1;
                        enter_seq((m_bits != 6'd0) ? SqBitSetup : SqUpdSetup);
                    end
                    SqUpdSetup: enter_seq(SqUpdHigh);
                    SqUpdHigh:  enter_seq(SqUpdHold);
                    SqRstHigh:  enter_seq(SqRstHold);
                    SqRstHold:  enter_seq(SqClkHigh);
                    SqClkHigh:  enter_seq(SqClkHold);
                    SqClkHold:  enter_seq(SqFqHigh);
                    SqFqHigh:   enter_seq(SqFqHold);
                    default:    enter_seq(SqIdle);
                endcase
            end
        end else begin
            case (rq.cmd)
                dsl_pkg::CmdSetPhase: st = accept_phase(rq.phase_step);
                // Up/down saturate; the kept value still goes through the limits.
                dsl_pkg::CmdPhaseUp:
                    st = accept_phase((m_phase < dsl_pkg::PhaseMax) ? m_phase + 5'd1 : m_phase);
                dsl_pkg::CmdPhaseDn:
                    st = accept_phase((m_phase > 5'd0) ? m_phase - 5'd1 : m_phase);
                dsl_pkg::CmdUpdate:   load_frame();
                dsl_pkg::CmdResetSeq: enter_seq(SqRstHigh);
                default: ;
            endcase
        end
        r.serial_clock  = (m_seq == SqBitHigh) || (m_seq == SqClkHigh);
        r.serial_data   = ((m_seq == SqBitSetup) || (m_seq == SqBitHigh)) && m_frame[0];
        r.update_strobe = (m_seq == SqUpdHigh) || (m_seq == SqFqHigh);
        r.chip_reset    = (m_seq == SqRstHigh);
        r.busy_res      = (m_seq != SqIdle);
        r.status        = st;
        r.phase_now     = m_phase;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request driver: offers queued requests, predicts on acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : req_driver
        logic taken;
        taken = i_valid && o_ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (taken) pin_expect_q.push_back(next_pin_state(i_data));
            if (i_valid && !taken) begin
                // hold the request until the block takes it
            end else if (req_q.size() != 0 && $urandom_range(99, 0) >= tx_gap_pct) begin
                i_data  <= req_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [4:0] want, logic [4:0] got);
        if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Result monitor: compares every accepted result with the oldest
    // prediction; also drives receiver back-pressure.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : res_monitor
        dsl_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pin_expect_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) $display("result with no request pending: %h", o_data);
                end else begin
                    want = pin_expect_q.pop_front();
                    check_field("serial_clock",  5'(want.serial_clock),  5'(o_data.serial_clock));
                    check_field("serial_data",   5'(want.serial_data),   5'(o_data.serial_data));
                    check_field("update_strobe", 5'(want.update_strobe), 5'(o_data.update_strobe));
                    check_field("chip_reset",    5'(want.chip_reset),    5'(o_data.chip_reset));
                    check_field("busy_res",      5'(want.busy_res),      5'(o_data.busy_res));
                    check_field("status",        5'(want.status),        5'(o_data.status));
                    check_field("phase_now",     want.phase_now,         o_data.phase_now);
                end
            end
            i_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off counts down on its own.
    always @(posedge i_clk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // Watchdog: a stretch past QuietLimit without a handshake on either side is a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("[dds_serial_word_loader] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (called at the falling edge)
    // ------------------------------------------------------------------
    task automatic push_req(logic [2:0] cmd, logic [4:0] ps);
        dsl_pkg::t_in_item rq;
        rq.cmd = cmd;
        rq.phase_step = ps;
        req_q.push_back(rq);
    endtask

    // Returns once every queued request has been taken and answered.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_q.size() != 0 || i_valid || pin_expect_q.size() != 0);
    endtask

    // Keep ticking until the predicted sequencer is back to idle.
    task automatic run_out();
        wait_drained();
        while (m_seq != SqIdle) begin
            repeat (DrainBatch) push_req(dsl_pkg::CmdTick, 5'($urandom_range(31, 0)));
            wait_drained();
        end
    endtask

    function automatic dsl_pkg::t_cfg mk_cfg(logic [31:0] tw, logic on, logic au,
                                             logic [7:0] su, logic [7:0] pu,
                                             logic [7:0] ho, logic [4:0] mn,
                                             logic [4:0] mx);
        dsl_pkg::t_cfg c;
        c.tuning_word    = tw;
        c.output_on      = on;
        c.auto_update    = au;
        c.setup_ticks    = su;
        c.pulse_ticks    = pu;
        c.hold_ticks     = ho;
        c.min_phase_step = mn;
        c.max_phase_step = mx;
        return c;
    endfunction

    // Writes all eight registers; bits above a register's width carry noise.
    task automatic apply_cfg(dsl_pkg::t_cfg c);
        logic [31:0] wd;
        logic [2:0]  ra;
        for (int k = 0; k < 8; k++) begin
            ra = 3'(k);
            wd = $urandom();
            case (ra)
                dsl_pkg::RegTuningWord: wd = c.tuning_word;
                dsl_pkg::RegOutputOn:   wd[0] = c.output_on;
                dsl_pkg::RegAutoUpdate: wd[0] = c.auto_update;
                dsl_pkg::RegSetupTicks: wd[7:0] = c.setup_ticks;
                dsl_pkg::RegPulseTicks: wd[7:0] = c.pulse_ticks;
                dsl_pkg::RegHoldTicks:  wd[7:0] = c.hold_ticks;
                dsl_pkg::RegMinPhase:   wd[4:0] = c.min_phase_step;
                dsl_pkg::RegMaxPhase:   wd[4:0] = c.max_phase_step;
                default: ;
            endcase
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= ra;
            i_cfg_wdata <= wd;
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_m = c;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [2:0]    cmd;
        int            r;
        dsl_pkg::t_cfg c;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        hold_left = 0;
        quiet_cycles = 0;
        fail_cnt = 0;
        tx_gap_pct = 9;
        rx_stall_pct = 9;
        // predictor starts from the reset state
        cfg_m = mk_cfg(32'd0, 1'b0, 1'b0, dsl_pkg::TicksReset, dsl_pkg::TicksReset,
                       dsl_pkg::TicksReset, 5'd0, dsl_pkg::PhaseMax);
        m_phase = '0;
        m_frame = '0;
        m_bits = '0;
        m_seq = SqIdle;
        m_ticks = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: commands at the field extremes, saturation, busy refusal
        apply_cfg(mk_cfg(32'hFFFF_FFFF, 1'b0, 1'b0, 8'd1, 8'd1, 8'd1, 5'd0,
                         dsl_pkg::PhaseMax));
        push_req(dsl_pkg::CmdTick, 5'd0);
        push_req(CmdSpare6, 5'd31);
        push_req(CmdSpare7, 5'd0);
        push_req(dsl_pkg::CmdPhaseDn, 5'd0);      // already at zero: stays
        push_req(dsl_pkg::CmdSetPhase, 5'd31);
        push_req(dsl_pkg::CmdPhaseUp, 5'd0);      // already at top: stays
        push_req(dsl_pkg::CmdSetPhase, 5'd0);
        push_req(dsl_pkg::CmdPhaseUp, 5'd31);
        push_req(dsl_pkg::CmdPhaseDn, 5'd0);
        push_req(dsl_pkg::CmdSetPhase, 5'd21);
        push_req(dsl_pkg::CmdUpdate, 5'd0);
        push_req(dsl_pkg::CmdSetPhase, 5'd3);     // every one of these lands while busy
        push_req(dsl_pkg::CmdResetSeq, 5'd0);
        push_req(dsl_pkg::CmdUpdate, 5'd0);
        push_req(dsl_pkg::CmdPhaseUp, 5'd0);
        run_out();
        push_req(dsl_pkg::CmdResetSeq, 5'd0);
        run_out();

        // zero tick registers act as one; min above max refuses every phase
        apply_cfg(mk_cfg(32'h5A5A_A5A5, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 5'd20, 5'd10));
        push_req(dsl_pkg::CmdSetPhase, 5'd15);
        push_req(dsl_pkg::CmdPhaseUp, 5'd0);
        wait_drained();

        // limits 3..10 with auto-update; a good phase starts a frame by itself
        apply_cfg(mk_cfg(32'h1234_5678, 1'b1, 1'b1, 8'd1, 8'd2, 8'd1, 5'd3, 5'd10));
        push_req(dsl_pkg::CmdSetPhase, 5'd2);
        push_req(dsl_pkg::CmdSetPhase, 5'd11);
        push_req(dsl_pkg::CmdSetPhase, 5'd10);
        repeat (20) push_req(dsl_pkg::CmdTick, 5'd0);
        wait_drained();
        // rewrite the word mid-frame: only the next frame may see it
        apply_cfg(mk_cfg(32'h8765_4321, 1'b0, 1'b1, 8'd1, 8'd2, 8'd1, 5'd3, 5'd10));
        run_out();
        push_req(dsl_pkg::CmdPhaseUp, 5'd0);      // 11 is above the max
        push_req(dsl_pkg::CmdPhaseDn, 5'd0);
        run_out();
        push_req(dsl_pkg::CmdSetPhase, 5'd3);
        run_out();

        // long pulse and hold through the reset sequence, long setup in a frame
        apply_cfg(mk_cfg(32'hC3C3_3C3C, 1'b0, 1'b0, 8'd1, 8'd60, 8'd40, 5'd0,
                         dsl_pkg::PhaseMax));
        push_req(dsl_pkg::CmdResetSeq, 5'd0);
        run_out();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        apply_cfg(mk_cfg(32'h0F0F_F0F0, 1'b1, 1'b0, 8'd5, 8'd1, 8'd1, 5'd0,
                         dsl_pkg::PhaseMax));
        push_req(dsl_pkg::CmdUpdate, 5'd0);
        run_out();

        // --- random phases, each with its own settings and idling pattern
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 71; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 71; end
                default: begin tx_gap_pct = 9; rx_stall_pct = 9; end
            endcase
            c = mk_cfg($urandom(), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                       8'($urandom_range(2, 0)), 8'($urandom_range(2, 0)),
                       8'($urandom_range(2, 0)), 5'($urandom_range(6, 0)),
                       5'($urandom_range(31, 25)));
            if (p == 3) begin
                c.min_phase_step = 5'($urandom_range(31, 0));
                c.max_phase_step = 5'($urandom_range(31, 0));
            end else if (p == 7) begin
                c.min_phase_step = 5'd0;
                c.max_phase_step = dsl_pkg::PhaseMax;
            end
            apply_cfg(c);
            for (int n = 0; n < 55; n++) begin
                r = $urandom_range(99, 0);
                if (r < 60) begin
                    cmd = dsl_pkg::CmdTick;
                end else begin
                    r = $urandom_range(99, 0);
                    if (r < 30)      cmd = dsl_pkg::CmdSetPhase;
                    else if (r < 45) cmd = dsl_pkg::CmdPhaseUp;
                    else if (r < 60) cmd = dsl_pkg::CmdPhaseDn;
                    else if (r < 75) cmd = dsl_pkg::CmdUpdate;
                    else if (r < 85) cmd = dsl_pkg::CmdResetSeq;
                    else             cmd = $urandom_range(1, 0) ? CmdSpare7 : CmdSpare6;
                end
                push_req(cmd, 5'($urandom_range(31, 0)));
            end
            if (p == 4) begin
                // receiver holds off while requests keep coming: the block fills up
                @(posedge i_clk);
                hold_left <= HoldCycles;
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("[dds_serial_word_loader] OK");
        else
            $display("[dds_serial_word_loader] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/dsl_pkg.sv
hw/rtl/dsl_seq.sv
hw/rtl/dsl_outq.sv
hw/rtl/dds_serial_word_loader.sv
sim/tb_top.sv
